// ===== sv/dct_pkg.sv =====
`timescale 1ns / 1ps

package dct_pkg;

    localparam int DATA_BITS       = 12;
    localparam int COEFF_FRAC_BITS = 14;
    localparam int STORE_BITS      = 16;
    localparam int LANES           = 8;
    localparam int COEF_W          = COEFF_FRAC_BITS + 2;
    localparam int PROD_W          = COEF_W + STORE_BITS;
    localparam int ACC_W           = PROD_W + 3;
    localparam int ADDR_W          = 3;

    // register index of the mode register (address bits above the byte offset)
    localparam logic [ADDR_W-3:0] REG_MODE = '0;
    localparam logic [2:0] LAST_IDX = 3'd7;

    // cos(k*pi/16), k = 0 holds 1/sqrt(2), 30 fraction bits
    localparam longint COS_Q30 [8] = '{
        64'd759250125, 64'd1053110176, 64'd992008094, 64'd892783698,
        64'd759250125, 64'd596538995,  64'd410903207, 64'd209476638
    };

    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef data_t [LANES-1:0] row_t;
    typedef logic [LANES-1:0][STORE_BITS-1:0] svec_t;
    typedef logic [LANES-1:0][COEF_W-1:0] cvec_t;
    typedef logic [LANES-1:0][ACC_W-1:0] avec_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] idx;
        row_t       row;
    } qent_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_ROW_WAIT,
        ST_COL_HOLD,
        ST_COL,
        ST_COL_WAIT
    } be_state_t;

    // matrix coefficient: forward uses F[k][n], inverse the transpose
    function automatic logic signed [COEF_W-1:0] mat_coef(input logic inv,
                                                         input logic [2:0] k,
                                                         input logic [2:0] n);
        logic [2:0] kk;
        logic [2:0] nn;
        logic [2:0] m;
        logic       neg;
        int         t;
        int         a;
        longint     c;
        kk = inv ? n : k;
        nn = inv ? k : n;
        t  = (2 * int'(nn) + 1) * int'(kk);
        a  = t % 32;
        if (kk == 3'd0) begin
            m   = 3'd0;
            neg = 1'b0;
        end else if (a < 8) begin
            m   = 3'(a);
            neg = 1'b0;
        end else if (a < 16) begin
            m   = 3'(16 - a);
            neg = 1'b1;
        end else if (a < 24) begin
            m   = 3'(a - 16);
            neg = 1'b1;
        end else begin
            m   = 3'(32 - a);
            neg = 1'b0;
        end
        c = (COS_Q30[m] + (longint'(1) << (29 - COEFF_FRAC_BITS))) >>> (30 - COEFF_FRAC_BITS);
        return neg ? COEF_W'(-c) : COEF_W'(c);
    endfunction

endpackage

// ===== sv/dct_fe.sv =====
`timescale 1ns / 1ps

module dct_fe import dct_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  row_t              s_row,
    output logic              q_valid,
    input  logic              q_ready,
    output qent_t             q_ent
);

    logic       mode_reg;
    logic [2:0] row_count_reg;
    qent_t      fifo_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[ADDR_W-1:2] == REG_MODE) ? {31'b0, mode_reg} : 32'b0;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_ent   = fifo_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            row_count_reg <= 3'd0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end else begin
            if (cfg_wr && paddr[ADDR_W-1:2] == REG_MODE) begin
                mode_reg <= pwdata[0];
            end
            if (push) begin
                row_count_reg <= row_count_reg + 3'd1;
                wr_ptr_reg    <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // each row is tagged with its place in the block and the mode it sees
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= '{mode: mode_reg, idx: row_count_reg, row: s_row};
        end
    end

endmodule

// ===== sv/dct_mac.sv =====
`timescale 1ns / 1ps

module dct_mac import dct_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mac_ctl_t ctl,
    input  cvec_t    coef,
    input  svec_t    data,
    output logic     done,
    output avec_t    acc
);

    logic [LANES-1:0][PROD_W-1:0] prod_reg;
    mac_ctl_t                     ctl1_reg;
    avec_t                        acc_reg;
    logic                         done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.valid && ctl1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            prod_reg[i] <= PROD_W'($signed(coef[i]) * $signed(data[i]));
            if (ctl1_reg.valid) begin
                if (ctl1_reg.first) begin
                    acc_reg[i] <= ACC_W'($signed(prod_reg[i]));
                end else begin
                    acc_reg[i] <= ACC_W'($signed(acc_reg[i]) + $signed(ACC_W'($signed(prod_reg[i]))));
                end
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ===== sv/dct_be.sv =====
`timescale 1ns / 1ps

module dct_be import dct_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    output logic  q_ready,
    input  qent_t q_ent,
    output logic  m_valid,
    input  logic  m_ready,
    output row_t  out_row,
    output logic  out_last
);

    localparam logic signed [ACC_W-1:0] ST_MAX = ACC_W'((64'sd1 <<< (STORE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ST_MIN = ACC_W'(-(64'sd1 <<< (STORE_BITS - 1)));
    localparam logic signed [ACC_W-1:0] DT_MAX = ACC_W'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] DT_MIN = ACC_W'(-(64'sd1 <<< (DATA_BITS - 1)));

    be_state_t  state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] col_k_reg, col_k_next;
    qent_t      cur_reg;
    logic       load_cur;

    mac_ctl_t   iss_ctl;
    cvec_t      iss_coef;
    svec_t      iss_x;
    logic       iss_col;
    mac_ctl_t   op_ctl_reg;
    cvec_t      op_coef_reg;
    svec_t      op_x_reg;
    logic       op_col_reg;

    svec_t      store_mem [8];
    svec_t      mem_rdata_reg;
    logic       st_we;
    svec_t      st_wdata;

    logic       mac_done;
    avec_t      mac_acc;

    logic       out_valid_reg;
    row_t       out_row_reg;
    logic       out_last_reg;
    logic       out_load;
    row_t       out_wdata;

    function automatic logic signed [ACC_W-1:0] round_half(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        mag = s[ACC_W-1] ? (~s + ACC_W'(1)) : s;
        rnd = (mag + (ACC_W'(1) << COEFF_FRAC_BITS)) >> (COEFF_FRAC_BITS + 1);
        return s[ACC_W-1] ? $signed(~rnd + ACC_W'(1)) : $signed(rnd);
    endfunction

    dct_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (op_ctl_reg),
        .coef    (op_coef_reg),
        .data    (op_col_reg ? mem_rdata_reg : op_x_reg),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    always_comb begin
        logic signed [ACC_W-1:0] r;
        for (int i = 0; i < LANES; i++) begin
            r = round_half($signed(mac_acc[i]));
            st_wdata[i]  = (r > ST_MAX) ? ST_MAX[STORE_BITS-1:0] :
                           (r < ST_MIN) ? ST_MIN[STORE_BITS-1:0] : r[STORE_BITS-1:0];
            out_wdata[i] = (r > DT_MAX) ? DT_MAX[DATA_BITS-1:0] :
                           (r < DT_MIN) ? DT_MIN[DATA_BITS-1:0] : r[DATA_BITS-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        col_k_next = col_k_reg;
        q_ready    = 1'b0;
        load_cur   = 1'b0;
        iss_ctl    = '0;
        iss_coef   = '0;
        iss_x      = '0;
        iss_col    = 1'b0;
        st_we      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    load_cur   = 1'b1;
                    step_next  = 3'd0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                iss_ctl.valid = 1'b1;
                iss_ctl.first = (step_reg == 3'd0);
                iss_ctl.last  = (step_reg == LAST_IDX);
                for (int i = 0; i < LANES; i++) begin
                    iss_coef[i] = mat_coef(cur_reg.mode, 3'(i), step_reg);
                    iss_x[i]    = STORE_BITS'($signed(cur_reg.row[step_reg]));
                end
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_IDX) begin
                    state_next = ST_ROW_WAIT;
                end
            end
            ST_ROW_WAIT: begin
                if (mac_done) begin
                    st_we      = 1'b1;
                    state_next = (cur_reg.idx == LAST_IDX) ? ST_COL_HOLD : ST_IDLE;
                end
            end
            ST_COL_HOLD: begin
                if (!out_valid_reg) begin
                    step_next  = 3'd0;
                    state_next = ST_COL;
                end
            end
            ST_COL: begin
                iss_ctl.valid = 1'b1;
                iss_ctl.first = (step_reg == 3'd0);
                iss_ctl.last  = (step_reg == LAST_IDX);
                iss_col       = 1'b1;
                for (int i = 0; i < LANES; i++) begin
                    iss_coef[i] = mat_coef(cur_reg.mode, col_k_reg, step_reg);
                end
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_IDX) begin
                    state_next = ST_COL_WAIT;
                end
            end
            ST_COL_WAIT: begin
                if (mac_done) begin
                    out_load   = 1'b1;
                    col_k_next = col_k_reg + 3'd1;
                    state_next = (col_k_reg == LAST_IDX) ? ST_IDLE : ST_COL_HOLD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            col_k_reg     <= 3'd0;
            op_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            col_k_reg  <= col_k_next;
            op_ctl_reg <= iss_ctl;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cur) begin
            cur_reg <= q_ent;
        end
        op_coef_reg <= iss_coef;
        op_x_reg    <= iss_x;
        op_col_reg  <= iss_col;
        if (out_load) begin
            out_row_reg  <= out_wdata;
            out_last_reg <= (col_k_reg == LAST_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[cur_reg.idx] <= st_wdata;
        end
        mem_rdata_reg <= store_mem[step_reg];
    end

    assign m_valid  = out_valid_reg;
    assign out_row  = out_row_reg;
    assign out_last = out_last_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_ROW_WAIT || state_reg == ST_COL_WAIT))
        else $error("mac result arrived outside a wait state");

    a_col_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COL) |-> !out_valid_reg)
        else $error("column batch issued while output register is occupied");

    a_out_from_col: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COL_WAIT))
        else $error("result row loaded outside the column pass");

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (col_k_reg == 3'd0))
        else $error("last row flagged before the eighth column result");

endmodule

// ===== sv/dct_8x8_forward_inverse_core.sv =====
`timescale 1ns / 1ps

// 8x8 two-dimensional forward / inverse dct. a block enters as eight row
// transactions of eight signed 12-bit values; the mode register (address 0,
// bit 0: 0 forward, 1 inverse) is sampled with each row, and the column pass
// uses the mode seen with the eighth row. rows pass through a small input queue
// into an eight-lane multiply-accumulate engine: each row pass takes the row, runs
// 8 accumulate steps and waits out the multiply-accumulate pipeline; after the
// eighth row the column pass yields eight result row transactions, each one once
// the previous one has been taken, the last one flagged by m_last_row. the
// eight-lane multiply-accumulate unit runs an 8-step accumulation for each pass.
// coefficients are Q1.14, each pass rounds half away from zero, row results
// saturate to 16 bits and final results to 12 bits. the input queue keeps
// taking rows, up to two, while a result row waits for m_ready.
module dct_8x8_forward_inverse_core import dct_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // row input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [DATA_BITS-1:0] s_in0,
    input  logic signed [DATA_BITS-1:0] s_in1,
    input  logic signed [DATA_BITS-1:0] s_in2,
    input  logic signed [DATA_BITS-1:0] s_in3,
    input  logic signed [DATA_BITS-1:0] s_in4,
    input  logic signed [DATA_BITS-1:0] s_in5,
    input  logic signed [DATA_BITS-1:0] s_in6,
    input  logic signed [DATA_BITS-1:0] s_in7,
    // result rows
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_BITS-1:0] m_out0,
    output logic signed [DATA_BITS-1:0] m_out1,
    output logic signed [DATA_BITS-1:0] m_out2,
    output logic signed [DATA_BITS-1:0] m_out3,
    output logic signed [DATA_BITS-1:0] m_out4,
    output logic signed [DATA_BITS-1:0] m_out5,
    output logic signed [DATA_BITS-1:0] m_out6,
    output logic signed [DATA_BITS-1:0] m_out7,
    output logic                        m_last_row
);

    row_t  s_row;
    row_t  out_row;
    logic  q_valid;
    logic  q_ready;
    qent_t q_ent;

    // gather the row ports into one vector
    assign s_row = {s_in7, s_in6, s_in5, s_in4, s_in3, s_in2, s_in1, s_in0};

    // front: config register, row numbering and the input queue
    dct_fe u_fe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_row   (s_row),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_ent   (q_ent)
    );

    // back: row and column passes, transpose store, result register
    dct_be u_be (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_ent    (q_ent),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_row  (out_row),
        .out_last (m_last_row)
    );

    // spread the result row over the output ports
    assign m_out0 = out_row[0];
    assign m_out1 = out_row[1];
    assign m_out2 = out_row[2];
    assign m_out3 = out_row[3];
    assign m_out4 = out_row[4];
    assign m_out5 = out_row[5];
    assign m_out6 = out_row[6];
    assign m_out7 = out_row[7];

endmodule

// ===== bench/tb_dct_8x8_forward_inverse_core.sv =====
`timescale 1ns / 1ps

module tb_dct_8x8_forward_inverse_core;
    import dct_pkg::*;

    // how long the watchdog tolerates a bus with no transaction at all
    localparam int WATCHDOG_LIMIT = 6000;
    // quiet time before a mode write, enough to drain the row queue and the
    // multiply-accumulate engine when no result row is outstanding
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_ROWS    = 320;

    typedef enum logic [1:0] {
        EXP_PREDICT,  // expected rows come from the predictor
        EXP_ZERO,     // whole block of zeros
        EXP_DC_MAX,   // only the dc term, clipped high
        EXP_DC_MIN    // only the dc term, clipped low
    } exp_kind_t;

    typedef struct {
        logic      mode;
        row_t      data;
        exp_kind_t kind;
    } stim_row_t;

    typedef struct packed {
        row_t vals;
        logic last;
    } result_row_t;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // configuration port
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // row input channel
    logic  s_valid = 1'b0;
    logic  s_ready;
    data_t s_in [8] = '{default: '0};

    // result channel
    logic  m_valid;
    logic  m_ready = 1'b0;
    data_t m_out [8];
    logic  m_last_row;

    dct_8x8_forward_inverse_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in0      (s_in[0]),
        .s_in1      (s_in[1]),
        .s_in2      (s_in[2]),
        .s_in3      (s_in[3]),
        .s_in4      (s_in[4]),
        .s_in5      (s_in[5]),
        .s_in6      (s_in[6]),
        .s_in7      (s_in[7]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out0     (m_out[0]),
        .m_out1     (m_out[1]),
        .m_out2     (m_out[2]),
        .m_out3     (m_out[3]),
        .m_out4     (m_out[4]),
        .m_out5     (m_out[5]),
        .m_out6     (m_out[6]),
        .m_out7     (m_out[7]),
        .m_last_row (m_last_row)
    );

    // ------------------------------------------------------------------
    // transform predictor: own copy of mode, row store and row counter
    // ------------------------------------------------------------------

    // cos(k*pi/16) with 30 fraction bits, k = 0 holding 1/sqrt(2)
    localparam longint COS30 [8] = '{
        759250125, 1053110176, 992008094, 892783698,
        759250125, 596538995,  410903207, 209476638
    };

    logic        pred_mode = 1'b0;
    longint      row_store [64];
    int unsigned rows_in_block = 0;
    result_row_t pending_rows [$];
    int          errors = 0;

    function automatic longint q_coef(int m);
        return (COS30[m] + (longint'(1) << (29 - COEFF_FRAC_BITS))) >>> (30 - COEFF_FRAC_BITS);
    endfunction

    // signed coefficient of frequency k at sample n: cos((2n+1)k pi/16)
    function automatic longint basis(int k, int n);
        int a;
        a = ((2 * n + 1) * k) % 32;
        if (k == 0)
            return q_coef(0);
        else if (a < 8)
            return q_coef(a);
        else if (a < 16)
            return -q_coef(16 - a);
        else if (a < 24)
            return -q_coef(a - 16);
        else
            return q_coef(32 - a);
    endfunction

    // half of the sum, rounded half away from zero
    function automatic longint round_half(longint s);
        longint mag;
        mag = (s < 0) ? -s : s;
        mag = (mag + (longint'(1) << COEFF_FRAC_BITS)) >>> (COEFF_FRAC_BITS + 1);
        return (s < 0) ? -mag : mag;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -(longint'(1) << (bits - 1));
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic void dct_1d(input logic inv, input longint x [8], output longint y [8]);
        longint acc;
        for (int o = 0; o < 8; o++) begin
            acc = 0;
            for (int i = 0; i < 8; i++)
                acc += inv ? basis(i, o) * x[i] : basis(o, i) * x[i];
            y[o] = round_half(acc);
        end
    endfunction

    // one accepted row: row pass into the store, column pass on the eighth
    function automatic void predict_rows(row_t r, exp_kind_t kind);
        longint      x [8];
        longint      y [8];
        result_row_t res;
        for (int i = 0; i < 8; i++)
            x[i] = longint'(r[i]);
        dct_1d(pred_mode, x, y);
        for (int i = 0; i < 8; i++)
            row_store[rows_in_block * 8 + i] = clip(y[i], STORE_BITS);
        if (rows_in_block == 7) begin
            result_row_t blk [8];
            for (int c = 0; c < 8; c++) begin
                for (int k = 0; k < 8; k++)
                    x[k] = row_store[k * 8 + c];
                dct_1d(pred_mode, x, y);
                for (int k = 0; k < 8; k++)
                    blk[k].vals[c] = data_t'(clip(y[k], DATA_BITS));
            end
            for (int k = 0; k < 8; k++) begin
                res.last = (k == 7);
                res.vals = blk[k].vals;
                // typed-in expectations for the obvious blocks
                if (kind != EXP_PREDICT)
                    res.vals = '0;
                if (k == 0 && kind == EXP_DC_MAX)
                    res.vals[0] = data_t'(2047);
                if (k == 0 && kind == EXP_DC_MIN)
                    res.vals[0] = data_t'(-2048);
                pending_rows.push_back(res);
            end
        end
        rows_in_block = (rows_in_block + 1) % 8;
    endfunction

    // ------------------------------------------------------------------
    // result checking, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result row transaction");
                errors++;
            end else begin
                result_row_t want;
                want = pending_rows.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (m_out[i] !== want.vals[i]) begin
                        $error("out%0d: expected %0d, got %0d", i, want.vals[i], m_out[i]);
                        errors++;
                    end
                end
                if (m_last_row !== want.last) begin
                    $error("last_row: expected %0b, got %0b", want.last, m_last_row);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on the row, result or configuration port
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off for back-pressure
    // ------------------------------------------------------------------
    int stall_pct = 0;
    int idle_pct = 0;
    bit hold_request = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    int rows_sent = 0;

    task automatic send_row(row_t r, exp_kind_t kind);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 8; i++)
            s_in[i] <= r[i];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_rows(r, kind);
        rows_sent++;
        @(negedge aclk);
    endtask

    // mode writes only with nothing in flight
    task automatic write_mode(logic m);
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pending_rows.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(REG_MODE) << 2;
        pwdata  <= 32'(m);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pred_mode = m;
    endtask

    function automatic row_t random_row();
        row_t r;
        int   style;
        int   base;
        style = $urandom_range(3);
        base = $urandom_range(4095) - 2048;
        for (int i = 0; i < 8; i++) begin
            case (style)
                0: r[i] = data_t'($urandom());
                1: r[i] = data_t'(int'($urandom_range(128)) - 64);
                2: r[i] = $urandom_range(1) ? data_t'(2047) : data_t'(-2048);
                default: r[i] = data_t'(clip(base + int'($urandom_range(32)) - 16, DATA_BITS));
            endcase
        end
        return r;
    endfunction

    function automatic row_t flat_row(int v);
        row_t r;
        for (int i = 0; i < 8; i++)
            r[i] = data_t'(v);
        return r;
    endfunction

    // directed blocks: zeros, all-max, all-min (forward), then a block whose
    // mode flips to inverse halfway so the column pass runs inverse
    stim_row_t directed [$];

    task automatic build_directed();
        stim_row_t e;
        for (int b = 0; b < 3; b++) begin
            for (int r = 0; r < 8; r++) begin
                e.mode = 1'b0;
                e.data = flat_row(b == 0 ? 0 : (b == 1 ? 2047 : -2048));
                e.kind = (r != 7) ? EXP_PREDICT :
                         (b == 0 ? EXP_ZERO : (b == 1 ? EXP_DC_MAX : EXP_DC_MIN));
                directed.push_back(e);
            end
        end
        for (int r = 0; r < 8; r++) begin
            e.mode = (r >= 4);
            e.kind = EXP_PREDICT;
            for (int i = 0; i < 8; i++)
                e.data[i] = ((i + r) % 2) ? data_t'(2047) : data_t'(-2048);
            if (r == 3)
                e.data = flat_row(1);
            if (r == 6)
                e.data = flat_row(-1);
            directed.push_back(e);
        end
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    initial begin
        int block_no;
        logic split;
        logic calm;
        build_directed();
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed part
        foreach (directed[j]) begin
            if (directed[j].mode !== pred_mode)
                write_mode(directed[j].mode);
            send_row(directed[j].data, directed[j].kind);
        end

        // random blocks, cycling through the idling phases
        block_no = 0;
        while (rows_sent < RANDOM_ROWS + directed.size()) begin
            if (block_no % 6 == 0)
                set_phase(block_no / 6);
            // no mode writes around the hold-off, so the sender keeps pushing
            calm = (block_no != 2 && block_no != 3);
            // long hold-off while the sender keeps pushing rows
            if (block_no == 2)
                hold_request = 1;
            if (calm && $urandom_range(3) == 0)
                write_mode(1'($urandom_range(1)));
            split = calm && ($urandom_range(7) == 0);
            for (int r = 0; r < 8; r++) begin
                if (split && r == 4)
                    write_mode(!pred_mode);
                send_row(random_row(), EXP_PREDICT);
            end
            block_no++;
        end
        s_valid <= 1'b0;

        wait (pending_rows.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dct_pkg.sv
sv/dct_fe.sv
sv/dct_mac.sv
sv/dct_be.sv
sv/dct_8x8_forward_inverse_core.sv
bench/tb_dct_8x8_forward_inverse_core.sv
